@@ rtl/fds_pkg.sv @@
// ----------------------------------------------------------------------------
// fds_pkg
// Shared types and codes of the frame data stack: field widths, action and
// status codes, controller states and the controller command group.
// ----------------------------------------------------------------------------
`default_nettype none

package fds_pkg;

	// Fixed field widths of the item and result beats.
	localparam int ACTION_W     = 3;
	localparam int OFFSET_W     = 10;
	localparam int DATA_W       = 32;
	localparam int STATUS_W     = 3;
	localparam int LEVEL_TAG_W  = 6;
	localparam int OFFSET_TAG_W = 16;
	localparam int COUNT_W      = 11;

	typedef logic [ACTION_W-1:0] action_code_t;
	typedef logic [STATUS_W-1:0] status_code_t;

	// Action codes.
	localparam action_code_t ACT_PUSH_AUTO  = 3'd0;
	localparam action_code_t ACT_PUSH_GIVEN = 3'd1;
	localparam action_code_t ACT_POP        = 3'd2;
	localparam action_code_t ACT_READ       = 3'd3;
	localparam action_code_t ACT_WRITE      = 3'd4;
	localparam action_code_t ACT_CALL       = 3'd5;
	localparam action_code_t ACT_LEAVE      = 3'd6;

	// Status codes.
	localparam status_code_t ST_OK         = 3'd0;
	localparam status_code_t ST_FULL       = 3'd1;
	localparam status_code_t ST_EMPTY      = 3'd2;
	localparam status_code_t ST_RANGE      = 3'd3;
	localparam status_code_t ST_FRAME_FULL = 3'd4;
	localparam status_code_t ST_NO_FRAME   = 3'd5;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/fds_ram.sv @@
// ----------------------------------------------------------------------------
// fds_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/fds_ctrl.sv @@
// ----------------------------------------------------------------------------
// fds_ctrl
// Controller of the frame data stack: takes one beat, lets the memories
// deliver their read data, then has the datapath update and load the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_ctrl
	import fds_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	assign accept = in_valid && in_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs: a new beat is taken only when the result register is free or drains now.
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = !out_valid_q || out_ready;
				cmd.capture = in_valid && (!out_valid_q || out_ready);
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.execute || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/fds_datapath.sv @@
// ----------------------------------------------------------------------------
// fds_datapath
// Datapath of the frame data stack: entry memories, frame base memory,
// stack and frame registers, the per-action update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_datapath
	import fds_pkg::*;
#(
	parameter int STACK_DEPTH = 1024,
	parameter int FRAME_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ctrl_cmd_t                  cmd,
	input  wire logic [ACTION_W-1:0]        action,
	input  wire logic                       global_scope,
	input  wire logic [OFFSET_W-1:0]        slot_offset,
	input  wire logic signed [DATA_W-1:0]   data_value,
	input  wire logic signed [DATA_W-1:0]   return_point,
	output logic      [STATUS_W-1:0]        status,
	output logic signed [DATA_W-1:0]        read_value,
	output logic      [LEVEL_TAG_W-1:0]     read_level_tag,
	output logic      [OFFSET_TAG_W-1:0]    read_offset_tag,
	output logic      [COUNT_W-1:0]         depth,
	output logic      [LEVEL_TAG_W-1:0]     frame_level,
	output logic      [COUNT_W-1:0]         frame_base,
	output logic signed [DATA_W-1:0]        saved_return
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int LW = $clog2(FRAME_DEPTH);
	localparam int IW = ((CW > OFFSET_W) ? CW : OFFSET_W) + 1;

	// Stack and frame state.
	logic [CW-1:0]     count_q, count_d;
	logic [LW-1:0]     level_q, level_d;
	logic [CW-1:0]     base_q, base_d;
	logic [DATA_W-1:0] ret_q, ret_d;

	// Captured beat.
	action_code_t             act_q;
	logic [OFFSET_W-1:0]      off_q;
	logic signed [DATA_W-1:0] val_q;
	logic [DATA_W-1:0]        retpt_q;
	logic [IW-1:0]            idx_q, idx_d;

	// Memory ports.
	logic [AW-1:0]           stk_raddr, stk_waddr;
	logic                    val_we, tag_we;
	logic [VALUE_WIDTH-1:0]  val_wdata, val_rdata;
	logic [LEVEL_TAG_W-1:0]  lvl_wdata, lvl_rdata;
	logic [OFFSET_TAG_W-1:0] ofs_wdata, ofs_rdata;
	logic                    frm_we;
	logic [LW-1:0]           frm_raddr, frm_waddr;
	logic [CW-1:0]           frm_wdata, frm_rdata;

	// Result of the update.
	status_code_t            status_d;
	logic [DATA_W-1:0]       rv_d;
	logic [LEVEL_TAG_W-1:0]  rl_d;
	logic [OFFSET_TAG_W-1:0] ro_d;

	// Result register.
	status_code_t            status_q;
	logic [DATA_W-1:0]       rv_q;
	logic [LEVEL_TAG_W-1:0]  rl_q;
	logic [OFFSET_TAG_W-1:0] ro_q;
	logic [COUNT_W-1:0]      depth_q;
	logic [LEVEL_TAG_W-1:0]  level_out_q;
	logic [COUNT_W-1:0]      base_out_q;
	logic [DATA_W-1:0]       ret_out_q;

	// Entry index of a read or write; frame 0 always starts at index zero.
	assign idx_d = (global_scope ? IW'(0) : IW'(base_q)) + IW'(slot_offset);

	// Read addresses are issued with the accepted beat.
	assign stk_raddr = (action == ACT_PUSH_AUTO) ? AW'(count_q - CW'(1)) : idx_d[AW-1:0];
	assign frm_raddr = level_q - LW'(1);

	// Capture the beat.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= action;
			off_q   <= slot_offset;
			val_q   <= data_value;
			retpt_q <= return_point;
			idx_q   <= idx_d;
		end
	end

	fds_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (val_we && cmd.execute),
		.waddr (stk_waddr),
		.wdata (val_wdata),
		.re    (cmd.capture),
		.raddr (stk_raddr),
		.rdata (val_rdata)
	);

	fds_ram #(.WIDTH(LEVEL_TAG_W), .DEPTH(STACK_DEPTH)) u_level_ram (
		.clk   (clk),
		.we    (tag_we && cmd.execute),
		.waddr (stk_waddr),
		.wdata (lvl_wdata),
		.re    (cmd.capture),
		.raddr (stk_raddr),
		.rdata (lvl_rdata)
	);

	fds_ram #(.WIDTH(OFFSET_TAG_W), .DEPTH(STACK_DEPTH)) u_offset_ram (
		.clk   (clk),
		.we    (tag_we && cmd.execute),
		.waddr (stk_waddr),
		.wdata (ofs_wdata),
		.re    (cmd.capture),
		.raddr (stk_raddr),
		.rdata (ofs_rdata)
	);

	fds_ram #(.WIDTH(CW), .DEPTH(FRAME_DEPTH)) u_frame_ram (
		.clk   (clk),
		.we    (frm_we && cmd.execute),
		.waddr (frm_waddr),
		.wdata (frm_wdata),
		.re    (cmd.capture),
		.raddr (frm_raddr),
		.rdata (frm_rdata)
	);

	// Per-action update, evaluated against the registered read data.
	always_comb begin
		status_d  = ST_OK;
		rv_d      = '0;
		rl_d      = '0;
		ro_d      = '0;
		count_d   = count_q;
		level_d   = level_q;
		base_d    = base_q;
		ret_d     = ret_q;
		val_we    = 1'b0;
		tag_we    = 1'b0;
		stk_waddr = count_q[AW-1:0];
		val_wdata = VALUE_WIDTH'(val_q);
		lvl_wdata = LEVEL_TAG_W'(level_q);
		ofs_wdata = ofs_rdata + OFFSET_TAG_W'(1);
		frm_we    = 1'b0;
		frm_waddr = level_q + LW'(1);
		frm_wdata = count_q;
		unique case (act_q) inside
			ACT_PUSH_AUTO, ACT_PUSH_GIVEN: begin
				if (count_q == CW'(STACK_DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					val_we  = 1'b1;
					tag_we  = 1'b1;
					count_d = count_q + CW'(1);
					if (act_q == ACT_PUSH_GIVEN) begin
						ofs_wdata = OFFSET_TAG_W'(off_q);
					end
					// The first entry of an empty stack holds value zero at level zero; an auto push also gives it offset tag zero.
					if (count_q == '0) begin
						val_wdata = '0;
						lvl_wdata = '0;
						if (act_q == ACT_PUSH_AUTO) begin
							ofs_wdata = '0;
						end
					end
				end
			end
			ACT_POP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			ACT_READ, ACT_WRITE: begin
				stk_waddr = idx_q[AW-1:0];
				if (idx_q >= IW'(count_q)) begin
					status_d = ST_RANGE;
				end else if (act_q == ACT_READ) begin
					rv_d = DATA_W'(val_rdata);
					rl_d = lvl_rdata;
					ro_d = ofs_rdata;
				end else begin
					val_we = 1'b1;
				end
			end
			ACT_CALL: begin
				if (level_q == LW'(FRAME_DEPTH - 1)) begin
					status_d = ST_FRAME_FULL;
				end else begin
					frm_we  = 1'b1;
					level_d = level_q + LW'(1);
					base_d  = count_q;
					ret_d   = retpt_q;
				end
			end
			ACT_LEAVE: begin
				if (level_q == '0) begin
					status_d = ST_NO_FRAME;
				end else begin
					// Truncation never grows the stack.
					if (base_q < count_q) begin
						count_d = base_q;
					end
					level_d = level_q - LW'(1);
					ret_d   = '1;
					base_d  = (level_q == LW'(1)) ? CW'(0) : frm_rdata;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Stack and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			level_q <= '0;
			base_q  <= '0;
			ret_q   <= '1;
		end else if (cmd.execute) begin
			count_q <= count_d;
			level_q <= level_d;
			base_q  <= base_d;
			ret_q   <= ret_d;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q    <= status_d;
			rv_q        <= rv_d;
			rl_q        <= rl_d;
			ro_q        <= ro_d;
			depth_q     <= COUNT_W'(count_d);
			level_out_q <= LEVEL_TAG_W'(level_d);
			base_out_q  <= COUNT_W'(base_d);
			ret_out_q   <= ret_d;
		end
	end

	assign status          = status_q;
	assign read_value      = rv_q;
	assign read_level_tag  = rl_q;
	assign read_offset_tag = ro_q;
	assign depth           = depth_q;
	assign frame_level     = level_out_q;
	assign frame_base      = base_out_q;
	assign saved_return    = ret_out_q;

endmodule

`default_nettype wire

@@ rtl/frame_data_stack.sv @@
// ----------------------------------------------------------------------------
// frame_data_stack
// Runtime data stack with call frames: push, pop, frame-relative read and
// write, call and leave, one result beat per item beat.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake           Payload
//   -------  ------------------  ---------------------------------------------
//   in       in_valid/in_ready   action, global_scope, slot_offset,
//                                data_value, return_point
//   out      out_valid/out_ready status, read_value, read_level_tag,
//                                read_offset_tag, depth, frame_level,
//                                frame_base, saved_return
//
// An item first reads the entry and frame base memories through their registered
// ports, then updates state, writes back and loads the result register. No new
// item is taken until the last one has loaded its result.
// A new item is taken while a result waits only in the cycle it drains.
// Reset clears depth, frame level and base and sets saved return to all ones;
// entry memory contents stay undefined until written, with no clearing pass.
//
`default_nettype none

module frame_data_stack
	import fds_pkg::*;
#(
	parameter int STACK_DEPTH = 1024,
	parameter int FRAME_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [ACTION_W-1:0]      action,
	input  wire logic                     global_scope,
	input  wire logic [OFFSET_W-1:0]      slot_offset,
	input  wire logic signed [DATA_W-1:0] data_value,
	input  wire logic signed [DATA_W-1:0] return_point,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [STATUS_W-1:0]           status,
	output logic signed [DATA_W-1:0]      read_value,
	output logic [LEVEL_TAG_W-1:0]        read_level_tag,
	output logic [OFFSET_TAG_W-1:0]       read_offset_tag,
	output logic [COUNT_W-1:0]            depth,
	output logic [LEVEL_TAG_W-1:0]        frame_level,
	output logic [COUNT_W-1:0]            frame_base,
	output logic signed [DATA_W-1:0]      saved_return
);

	ctrl_cmd_t cmd;

	fds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	fds_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.FRAME_DEPTH (FRAME_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.action          (action),
		.global_scope    (global_scope),
		.slot_offset     (slot_offset),
		.data_value      (data_value),
		.return_point    (return_point),
		.status          (status),
		.read_value      (read_value),
		.read_level_tag  (read_level_tag),
		.read_offset_tag (read_offset_tag),
		.depth           (depth),
		.frame_level     (frame_level),
		.frame_base      (frame_base),
		.saved_return    (saved_return)
	);

endmodule

`default_nettype wire

@@ rtl/fds_checker.sv @@
// ----------------------------------------------------------------------------
// fds_checker
// Port-level checks of the frame data stack: result timing, back-pressure
// and consistency of the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_checker
	import fds_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic [STATUS_W-1:0]      status,
	input wire logic signed [DATA_W-1:0] read_value,
	input wire logic [LEVEL_TAG_W-1:0]   read_level_tag,
	input wire logic [OFFSET_TAG_W-1:0]  read_offset_tag,
	input wire logic [COUNT_W-1:0]       depth,
	input wire logic [COUNT_W-1:0]       frame_base,
	input wire logic signed [DATA_W-1:0] saved_return
);

	// Every item beat yields a result beat on out_valid.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("no result two cycles after an item beat");

	// No item is taken while a stalled result still sits in the output register.
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while a result is stalled");

	// Items are worked on one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken during execution");

	// Read fields are zero on any failed step.
	a_read_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |->
			(read_value == '0) && (read_level_tag == '0) && (read_offset_tag == '0))
		else $error("read fields set on a failed step");

	// A stalled result holds its valid, status, depth, frame base and saved return.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(depth)
			&& $stable(frame_base) && $stable(saved_return))
		else $error("stalled result changed");

endmodule

bind frame_data_stack fds_checker u_fds_checker (.*);

`default_nettype wire

@@ tb/frame_data_stack_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_data_stack_tb
// Self-checking bench for the frame data stack. A short directed table covers
// the empty and reset cases, the value and offset extremes and frame entry and
// exit. Random traffic follows, with a climb to the deepest frame and a fill
// to the full stack. Every result beat is checked field by field against a
// behavioral copy of the stack that runs as each item beat is taken.
// ----------------------------------------------------------------------------

module frame_data_stack_tb
	import fds_pkg::*;
;

	localparam int STACK_DEPTH = 1024;
	localparam int FRAME_DEPTH = 64;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam action_code_t ACT_UNDEFINED = 3'd7;

	typedef struct packed {
		action_code_t             act;
		logic                     glob;
		logic [OFFSET_W-1:0]      off;
		logic [DATA_W-1:0]        data;
		logic [DATA_W-1:0]        ret;
	} op_t;

	typedef struct packed {
		status_code_t             status;
		logic [DATA_W-1:0]        rd_value;
		logic [LEVEL_TAG_W-1:0]   rd_level;
		logic [OFFSET_TAG_W-1:0]  rd_tag;
		logic [COUNT_W-1:0]       depth;
		logic [LEVEL_TAG_W-1:0]   level;
		logic [COUNT_W-1:0]       base;
		logic [DATA_W-1:0]        ret;
	} stack_result_t;

	// Fields of a directed row that are written down by hand.
	typedef struct packed {
		logic                     on;
		status_code_t             status;
		logic [COUNT_W-1:0]       depth;
		logic [LEVEL_TAG_W-1:0]   level;
		logic [DATA_W-1:0]        ret;
	} pinned_t;

	typedef struct packed {
		op_t     op;
		pinned_t pin;
	} dir_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [ACTION_W-1:0]         action = ACT_PUSH_AUTO;
	logic                        global_scope = 1'b0;
	logic [OFFSET_W-1:0]         slot_offset = '0;
	logic signed [DATA_W-1:0]    data_value = '0;
	logic signed [DATA_W-1:0]    return_point = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [STATUS_W-1:0]         status;
	logic signed [DATA_W-1:0]    read_value;
	logic [LEVEL_TAG_W-1:0]      read_level_tag;
	logic [OFFSET_TAG_W-1:0]     read_offset_tag;
	logic [COUNT_W-1:0]          depth;
	logic [LEVEL_TAG_W-1:0]      frame_level;
	logic [COUNT_W-1:0]          frame_base;
	logic signed [DATA_W-1:0]    saved_return;

	frame_data_stack #(
		.STACK_DEPTH(STACK_DEPTH),
		.FRAME_DEPTH(FRAME_DEPTH),
		.VALUE_WIDTH(DATA_W)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.global_scope   (global_scope),
		.slot_offset    (slot_offset),
		.data_value     (data_value),
		.return_point   (return_point),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.read_value     (read_value),
		.read_level_tag (read_level_tag),
		.read_offset_tag(read_offset_tag),
		.depth          (depth),
		.frame_level    (frame_level),
		.frame_base     (frame_base),
		.saved_return   (saved_return)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Behavioral copy of the stack, advanced once per accepted item beat.
	logic [DATA_W-1:0]       mdl_value [0:STACK_DEPTH-1];
	logic [LEVEL_TAG_W-1:0]  mdl_ltag [0:STACK_DEPTH-1];
	logic [OFFSET_TAG_W-1:0] mdl_otag [0:STACK_DEPTH-1];
	logic [COUNT_W-1:0]      mdl_base [0:FRAME_DEPTH-1];
	logic [COUNT_W-1:0]      mdl_count;
	logic [LEVEL_TAG_W-1:0]  mdl_level;
	logic [DATA_W-1:0]       mdl_ret;

	stack_result_t awaited_results[$];

	int  beats_in = 0;
	int  beats_out = 0;
	int  mismatches = 0;
	int  status_seen [0:7];
	int  peak_depth = 0;
	int  peak_level = 0;
	int  idle_cycles = 0;
	bit  calm = 1'b0;
	bit  hold_request = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	bit  tx_bursty = 1'b0;
	int  tx_left = 0;
	bit  rx_bursty = 1'b0;
	int  rx_left = 0;
	int  stall_left = 0;

	// Applies one operation to the behavioral stack and returns its result beat.
	function automatic stack_result_t frame_stack_step(input op_t op);
		stack_result_t           res;
		int                      base;
		int                      idx;
		logic [OFFSET_TAG_W-1:0] tag;
		res = '0;
		res.status = ST_OK;
		case (op.act)
			ACT_PUSH_AUTO, ACT_PUSH_GIVEN: begin
				if (int'(mdl_count) >= STACK_DEPTH) begin
					res.status = ST_FULL;
				end else if (mdl_count == 0) begin
					// The first entry always holds zero at level zero.
					mdl_value[0] = '0;
					mdl_ltag[0] = '0;
					mdl_otag[0] = (op.act == ACT_PUSH_GIVEN) ? OFFSET_TAG_W'(op.off) : '0;
					mdl_count = COUNT_W'(1);
				end else begin
					tag = (op.act == ACT_PUSH_GIVEN) ? OFFSET_TAG_W'(op.off)
						: mdl_otag[SAW'(mdl_count - COUNT_W'(1))] + OFFSET_TAG_W'(1);
					mdl_value[SAW'(mdl_count)] = op.data;
					mdl_ltag[SAW'(mdl_count)] = mdl_level;
					mdl_otag[SAW'(mdl_count)] = tag;
					mdl_count = mdl_count + COUNT_W'(1);
				end
			end
			ACT_POP: begin
				if (mdl_count == 0)
					res.status = ST_EMPTY;
				else
					mdl_count = mdl_count - COUNT_W'(1);
			end
			ACT_READ, ACT_WRITE: begin
				base = op.glob ? int'(mdl_base[0]) : int'(mdl_base[mdl_level]);
				idx = base + int'(op.off);
				if (idx >= int'(mdl_count)) begin
					res.status = ST_RANGE;
				end else if (op.act == ACT_READ) begin
					res.rd_value = mdl_value[SAW'(idx)];
					res.rd_level = mdl_ltag[SAW'(idx)];
					res.rd_tag = mdl_otag[SAW'(idx)];
				end else begin
					mdl_value[SAW'(idx)] = op.data;
				end
			end
			ACT_CALL: begin
				if (int'(mdl_level) + 1 >= FRAME_DEPTH) begin
					res.status = ST_FRAME_FULL;
				end else begin
					mdl_level = mdl_level + LEVEL_TAG_W'(1);
					mdl_base[mdl_level] = mdl_count;
					mdl_ret = op.ret;
				end
			end
			ACT_LEAVE: begin
				if (mdl_level == 0) begin
					res.status = ST_NO_FRAME;
				end else begin
					// Truncation only ever shrinks the stack.
					if (mdl_base[mdl_level] < mdl_count)
						mdl_count = mdl_base[mdl_level];
					mdl_level = mdl_level - LEVEL_TAG_W'(1);
					mdl_ret = '1;
				end
			end
			default: ;
		endcase
		res.depth = mdl_count;
		res.level = mdl_level;
		res.base = mdl_base[mdl_level];
		res.ret = mdl_ret;
		return res;
	endfunction

	// Builds a random operation of the given kind. Reads and writes mostly land
	// inside the addressed frame, sometimes one past the top, else anywhere.
	function automatic op_t random_op_of(input action_code_t act);
		op_t op;
		int  base;
		int  span;
		int  roll;
		op.act = act;
		op.glob = 1'($urandom_range(0, 1));
		op.off = OFFSET_W'($urandom);
		op.ret = $urandom;
		case ($urandom_range(0, 9))
			0: op.data = 32'h8000_0000;
			1: op.data = 32'h7FFF_FFFF;
			2: op.data = '1;
			default: op.data = $urandom;
		endcase
		if (act == ACT_READ || act == ACT_WRITE) begin
			base = op.glob ? int'(mdl_base[0]) : int'(mdl_base[mdl_level]);
			span = int'(mdl_count) - base;
			roll = $urandom_range(0, 9);
			if (span > 0 && roll < 8)
				op.off = OFFSET_W'($urandom_range(0, span - 1));
			else if (roll == 8 && span >= 0 && span < (1 << OFFSET_W))
				op.off = OFFSET_W'(span);
		end
		return op;
	endfunction

	function automatic op_t random_op();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 18)      return random_op_of(ACT_PUSH_AUTO);
		else if (pick < 30) return random_op_of(ACT_PUSH_GIVEN);
		else if (pick < 44) return random_op_of(ACT_POP);
		else if (pick < 62) return random_op_of(ACT_READ);
		else if (pick < 77) return random_op_of(ACT_WRITE);
		else if (pick < 87) return random_op_of(ACT_CALL);
		else if (pick < 97) return random_op_of(ACT_LEAVE);
		else                return random_op_of(ACT_UNDEFINED);
	endfunction

	// Offers one item beat, waits for it to be taken and records its result.
	task automatic offer_op(input op_t op, input pinned_t pin);
		stack_result_t want;
		if (tx_left == 0) begin
			tx_bursty = 1'($urandom_range(0, 1));
			tx_left = $urandom_range(16, 48);
		end else begin
			tx_left--;
		end
		if (!calm && tx_bursty && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= op.act;
		global_scope <= op.glob;
		slot_offset  <= op.off;
		data_value   <= op.data;
		return_point <= op.ret;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_in++;
		want = frame_stack_step(op);
		if (pin.on) begin
			want.status = pin.status;
			want.depth = pin.depth;
			want.level = pin.level;
			want.ret = pin.ret;
		end
		awaited_results = {awaited_results, want};
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Result side: compare each beat with the oldest pending expectation.
	always @(posedge clk) begin : result_check
		stack_result_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (awaited_results.size() == 0) begin
				$error("result beat arrived with no item pending");
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("status", DATA_W'(want.status), DATA_W'(status));
				check_field("read_value", want.rd_value, read_value);
				check_field("read_level_tag", DATA_W'(want.rd_level), DATA_W'(read_level_tag));
				check_field("read_offset_tag", DATA_W'(want.rd_tag), DATA_W'(read_offset_tag));
				check_field("depth", DATA_W'(want.depth), DATA_W'(depth));
				check_field("frame_level", DATA_W'(want.level), DATA_W'(frame_level));
				check_field("frame_base", DATA_W'(want.base), DATA_W'(frame_base));
				check_field("saved_return", want.ret, saved_return);
			end
			status_seen[status]++;
			if (int'(depth) > peak_depth) peak_depth = int'(depth);
			if (int'(frame_level) > peak_level) peak_level = int'(frame_level);
		end
	end

	// Result receiver: random stall bursts, quiet stretches, one long hold-off.
	always @(posedge clk) begin
		if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (rx_left == 0) begin
			rx_bursty = 1'($urandom_range(0, 1));
			rx_left = $urandom_range(20, 60);
		end else begin
			rx_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (rx_bursty && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 5);
		end
	end

	// Watchdog on cycles without any beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", idle_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Directed rows: empty-stack errors, value extremes, offset tags,
	// frame entry and exit, and a leave whose base lies above the top.
	dir_row_t dir_rows [0:23] = '{
		'{'{ACT_POP,        1'b0, 10'd0,    32'h0,         32'h0},
			'{1'b1, ST_EMPTY,    11'd0, 6'd0, 32'hFFFF_FFFF}},
		'{'{ACT_LEAVE,      1'b0, 10'd0,    32'h0,         32'h0},
			'{1'b1, ST_NO_FRAME, 11'd0, 6'd0, 32'hFFFF_FFFF}},
		'{'{ACT_READ,       1'b1, 10'd0,    32'h0,         32'h0},
			'{1'b1, ST_RANGE,    11'd0, 6'd0, 32'hFFFF_FFFF}},
		'{'{ACT_WRITE,      1'b0, 10'd1023, 32'h7FFF_FFFF, 32'h0},
			'{1'b1, ST_RANGE,    11'd0, 6'd0, 32'hFFFF_FFFF}},
		'{'{ACT_UNDEFINED,  1'b1, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
			'{1'b1, ST_OK,       11'd0, 6'd0, 32'hFFFF_FFFF}},
		'{'{ACT_PUSH_AUTO,  1'b0, 10'd0,    32'h7FFF_FFFF, 32'h0},
			'{1'b1, ST_OK,       11'd1, 6'd0, 32'hFFFF_FFFF}},
		'{'{ACT_READ,       1'b1, 10'd0,    32'h0,         32'h0}, '0},
		'{'{ACT_PUSH_AUTO,  1'b0, 10'd1023, 32'h8000_0000, 32'h0}, '0},
		'{'{ACT_PUSH_GIVEN, 1'b1, 10'd1023, 32'h7FFF_FFFF, 32'h0}, '0},
		'{'{ACT_PUSH_AUTO,  1'b0, 10'd0,    32'hFFFF_FFFF, 32'h0}, '0},
		'{'{ACT_READ,       1'b1, 10'd3,    32'h0,         32'h0}, '0},
		'{'{ACT_WRITE,      1'b1, 10'd1,    32'h7FFF_FFFF, 32'h0}, '0},
		'{'{ACT_READ,       1'b0, 10'd1,    32'h0,         32'h0}, '0},
		'{'{ACT_READ,       1'b1, 10'd4,    32'h0,         32'h0},
			'{1'b1, ST_RANGE,    11'd4, 6'd0, 32'hFFFF_FFFF}},
		'{'{ACT_CALL,       1'b0, 10'd0,    32'h0,         32'h8000_0000},
			'{1'b1, ST_OK,       11'd4, 6'd1, 32'h8000_0000}},
		'{'{ACT_PUSH_GIVEN, 1'b0, 10'd0,    32'h1234_5678, 32'h0}, '0},
		'{'{ACT_READ,       1'b0, 10'd0,    32'h0,         32'h0}, '0},
		'{'{ACT_READ,       1'b1, 10'd2,    32'h0,         32'h0}, '0},
		'{'{ACT_POP,        1'b0, 10'd0,    32'h0,         32'h0}, '0},
		'{'{ACT_POP,        1'b0, 10'd0,    32'h0,         32'h0}, '0},
		'{'{ACT_READ,       1'b0, 10'd0,    32'h0,         32'h0},
			'{1'b1, ST_RANGE,    11'd3, 6'd1, 32'h8000_0000}},
		'{'{ACT_CALL,       1'b1, 10'd0,    32'h0,         32'h7FFF_FFFF},
			'{1'b1, ST_OK,       11'd3, 6'd2, 32'h7FFF_FFFF}},
		'{'{ACT_LEAVE,      1'b0, 10'd0,    32'h0,         32'h0},
			'{1'b1, ST_OK,       11'd3, 6'd1, 32'hFFFF_FFFF}},
		'{'{ACT_LEAVE,      1'b0, 10'd0,    32'h0,         32'h0},
			'{1'b1, ST_OK,       11'd3, 6'd0, 32'hFFFF_FFFF}}
	};

	initial begin : stimulus
		op_t op;
		foreach (status_seen[i]) status_seen[i] = 0;
		mdl_count = '0;
		mdl_level = '0;
		mdl_base[0] = '0;
		mdl_ret = '1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) offer_op(dir_rows[i].op, dir_rows[i].pin);

		repeat (250) offer_op(random_op(), '0);

		// Climb to the deepest frame, try two more calls, then unwind fully.
		while (int'(mdl_level) < FRAME_DEPTH - 1) begin
			offer_op(random_op_of(ACT_CALL), '0);
			if ($urandom_range(0, 1) == 0) offer_op(random_op_of(ACT_PUSH_AUTO), '0);
		end
		repeat (2) offer_op(random_op_of(ACT_CALL), '0);
		while (mdl_level != 0) begin
			if ($urandom_range(0, 2) == 0) offer_op(random_op_of(ACT_READ), '0);
			offer_op(random_op_of(ACT_LEAVE), '0);
		end
		offer_op(random_op_of(ACT_LEAVE), '0);

		// Fill the stack inside a fresh frame, the receiver holding off as it starts,
		// hit the full case and the last slot, then drop the frame.
		offer_op(random_op_of(ACT_CALL), '0);
		hold_request = 1'b1;
		while (int'(mdl_count) < STACK_DEPTH)
			offer_op(random_op_of($urandom_range(0, 1) ? ACT_PUSH_AUTO : ACT_PUSH_GIVEN), '0);
		offer_op(random_op_of(ACT_PUSH_AUTO), '0);
		offer_op(random_op_of(ACT_PUSH_GIVEN), '0);
		op = random_op_of(ACT_READ);
		op.glob = 1'b1;
		op.off = '1;
		offer_op(op, '0);
		op.act = ACT_WRITE;
		offer_op(op, '0);
		op.act = ACT_READ;
		offer_op(op, '0);
		offer_op(random_op_of(ACT_LEAVE), '0);

		for (int n = 0; n < 250; n++) begin
			if (n == 100) calm = 1'b1;
			offer_op(random_op(), '0);
		end
		in_valid <= 1'b0;

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Stack run: %0d item beats, %0d result beats, peak depth %0d, peak frame %0d.",
			beats_in, beats_out, peak_depth, peak_level);
		$display("Status mix: ok %0d, full %0d, empty %0d, range %0d, frame full %0d, no frame %0d.",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
			status_seen[ST_RANGE], status_seen[ST_FRAME_FULL], status_seen[ST_NO_FRAME]);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ frame_data_stack.f @@
rtl/fds_pkg.sv
rtl/fds_ram.sv
rtl/fds_ctrl.sv
rtl/fds_datapath.sv
rtl/frame_data_stack.sv
rtl/fds_checker.sv
tb/frame_data_stack_tb.sv
